### rtl/ava_pkg.sv
// Package for the voice allocator: sizes, codes and the cell/ring record.
package ava_pkg;
   localparam int NUM_VOICES = 16;
   localparam int NUM_SOUNDS = 64;
   localparam int VW = $clog2(NUM_VOICES);
   localparam int SW = $clog2(NUM_SOUNDS);
   localparam logic [6:0] PRIO_CEILING = 7'd101;

   typedef enum logic [2:0] {
      OP_PLAY = 3'd0, OP_START_LOOP = 3'd1, OP_STOP_LOOP = 3'd2, OP_RETIRE = 3'd3,
      OP_PAUSE = 3'd4, OP_RESUME = 3'd5, OP_RESET = 3'd6, OP_CLEAR_WORLD = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_INVALID = 3'd1, ST_MISSING = 3'd2, ST_CONFLICT = 3'd3,
      ST_PAUSED = 3'd4, ST_COOLDOWN = 3'd5, ST_CAPACITY = 3'd6, ST_PRIORITY = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      RS_NONE = 2'd0, RS_INSTANCE = 2'd1, RS_GLOBAL = 2'd2
   } reason_type;

   typedef enum logic [1:0] {
      FSM_IDLE, FSM_SCAN, FSM_DECIDE, FSM_DONE
   } fsm_type;

   // One voice record circulating in the ring.
   typedef struct packed {
      logic        active;
      logic        stopping;
      logic [6:0]  sound;
      logic [63:0] key;
      logic [31:0] start;
      logic [6:0]  prio;
      logic        world;
   } voice_type;
endpackage

### rtl/ava_cell.sv
// One stage of the voice ring: holds one record and hands it on each cycle while shift is high.
module ava_cell
   import ava_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  voice_type d,
   output voice_type q
);
   voice_type q_ff;
   voice_type q_in;

   always_comb begin
      q_in = shift ? d : q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.active   <= 1'b0;
         q_ff.stopping <= 1'b0;
      end else begin
         q_ff.active   <= q_in.active;
         q_ff.stopping <= q_in.stopping;
      end
      q_ff.sound <= q_in.sound;
      q_ff.key   <= q_in.key;
      q_ff.start <= q_in.start;
      q_ff.prio  <= q_in.prio;
      q_ff.world <= q_in.world;
   end

   assign q = q_ff;
endmodule

### rtl/audio_voice_allocator.sv
// Top level of the voice allocator: command sequencer around a ring of voice cells.
//
// The voice table lives in a ring of NUM_VOICES cells. Every command makes the
// records rotate once around the ring, with the head record inspected and
// updated by the sequencer; a play or start_loop command that takes a voice
// rotates twice, the first pass gathering free slot, loop match, instance count,
// oldest instance and the steal victim, the second pass writing the chosen slot.
// req_tready is high only while idle with no result pending; the result sits in
// an output register until taken. Sound cooldown state is a per-sound array
// read through a register, with started bits cleared at reset.
// Configure csr_ only while idle.
module audio_voice_allocator
   import ava_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [6:0]   csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata from bit 0: op[3] sound_id[7] loop_id[64] now_frame[32]
   // priority_req[7] instance_cap[8] drop_new[1] cooldown_frames[24]
   // is_loop_sound[1] freezes[1] world_bus[1] voice_index[4], pad to 160
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata from bit 0: status[3] slot[4] evicted_id[64] steal_cause[2], pad to 80
   output logic [79:0]  rsp_tdata
);
   // request fields
   op_type      r_op;
   logic [6:0]  r_handle;
   logic [63:0] r_key;
   logic [31:0] r_now;
   logic [6:0]  r_prio;
   logic [7:0]  r_maxi;
   logic        r_drop;
   logic [23:0] r_cool;
   logic        r_loopok, r_freeze, r_world;
   logic [3:0]  r_vidx;

   logic [159:0] req_ff;
   logic [6:0]   count_ff;
   logic         paused_ff;
   fsm_type      state_ff, state_in;
   logic [VW:0]  cnt_ff;
   logic         pass_ff;   // 0 scan, 1 write
   logic [VW-1:0] pos_ff;   // voice index of the head record

   // scan results
   logic          vac_v_ff, ex_v_ff, same_v_ff, vic_v_ff;
   logic [VW-1:0] vac_ff, ex_ff, same_ff, vic_ff;
   logic [6:0]    ex_snd_ff, vic_prio_ff;
   logic [31:0]   same_st_ff, vic_st_ff;
   logic [VW:0]   inst_ff;
   logic          tgt_v_ff;
   logic [VW-1:0] tgt_ff;

   // sound table
   logic [NUM_SOUNDS-1:0] started_ff;
   logic [31:0]           last_ff [NUM_SOUNDS];
   logic [31:0]           last_rd_ff;

   // result register
   logic        out_v_ff;
   status_type  st_ff;
   logic [3:0]  slot_ff;
   logic [63:0] evk_ff;
   reason_type  rs_ff;

   assign r_op     = op_type'(req_ff[2:0]);
   assign r_handle = req_ff[9:3];
   assign r_key    = req_ff[73:10];
   assign r_now    = req_ff[105:74];
   assign r_prio   = req_ff[112:106];
   assign r_maxi   = req_ff[120:113];
   assign r_drop   = req_ff[121];
   assign r_cool   = req_ff[145:122];
   assign r_loopok = req_ff[146];
   assign r_freeze = req_ff[147];
   assign r_world  = req_ff[148];
   assign r_vidx   = req_ff[152:149];

   // ring
   voice_type ring_q [NUM_VOICES];
   voice_type head, head_new;
   logic      shift;
   assign head = ring_q[NUM_VOICES-1];

   for (genvar g = 0; g < NUM_VOICES; g++) begin : g_ring
      voice_type d;
      if (g == 0) begin : g_head
         assign d = head_new;
      end else begin : g_body
         assign d = ring_q[g-1];
      end
      ava_cell u_cell (.clock(clock), .reset(reset), .shift(shift), .d(d), .q(ring_q[g]));
   end

   logic        is_play;
   logic [SW-1:0] sidx;
   logic        hmiss;
   assign is_play = (r_op == OP_PLAY) || (r_op == OP_START_LOOP);
   assign sidx = SW'(r_handle - 7'd1);
   assign hmiss = (r_handle == 7'd0) || (r_handle > count_ff) ||
                  (r_handle > 7'(NUM_SOUNDS));

   // early checks before scanning (loop match needs scan, done in decide)
   status_type pre_st;
   always_comb begin
      pre_st = ST_OK;
      if (hmiss) pre_st = ST_MISSING;
      else if (r_op == OP_START_LOOP && (r_key == 64'd0 || !r_loopok)) pre_st = ST_INVALID;
      else if (r_op == OP_PLAY && r_key != 64'd0) pre_st = ST_INVALID;
   end

   logic hit;
   assign hit = head.active && (r_key != 64'd0) && (head.key == r_key);

   // decision after scan
   status_type dec_st;
   reason_type dec_rs;
   logic       dec_go;
   logic [VW-1:0] dec_tgt;
   always_comb begin
      dec_st = ST_OK; dec_rs = RS_NONE; dec_go = 1'b0; dec_tgt = vac_ff;
      if (pre_st != ST_OK) dec_st = pre_st;
      else if (r_op == OP_START_LOOP && ex_v_ff) begin
         if (ex_snd_ff != r_handle) dec_st = ST_CONFLICT;
         else dec_tgt = ex_ff;
      end else if (paused_ff && r_freeze) dec_st = ST_PAUSED;
      else if (started_ff[sidx] && ((r_now - last_rd_ff) < {8'd0, r_cool})) dec_st = ST_COOLDOWN;
      else if ({{(8-VW-1){1'b0}}, inst_ff} >= r_maxi) begin
         if (r_drop || !same_v_ff) dec_st = ST_CAPACITY;
         else begin dec_go = 1'b1; dec_tgt = same_ff; dec_rs = RS_INSTANCE; end
      end else if (!vac_v_ff) begin
         if (!vic_v_ff || r_prio < vic_prio_ff) dec_st = ST_PRIORITY;
         else begin dec_go = 1'b1; dec_tgt = vic_ff; dec_rs = RS_GLOBAL; end
      end else dec_go = 1'b1;
   end

   // head record update on each ring step
   always_comb begin
      head_new = head;
      if (state_ff == FSM_SCAN) begin
         case (r_op)
            OP_STOP_LOOP: if (hit && (!ex_v_ff)) begin
               head_new.key = 64'd0; head_new.stopping = 1'b1;
            end
            OP_RETIRE: if (pos_ff == VW'(r_vidx) && int'(r_vidx) < NUM_VOICES) begin
               head_new.active = 1'b0; head_new.stopping = 1'b0;
            end
            OP_RESET: begin head_new.active = 1'b0; head_new.stopping = 1'b0; end
            OP_CLEAR_WORLD: if (head.active && head.world) begin
               head_new.active = 1'b0; head_new.stopping = 1'b0;
            end
            default: if (pass_ff && tgt_v_ff && pos_ff == tgt_ff) begin
               head_new.active = 1'b1; head_new.stopping = 1'b0;
               head_new.sound = r_handle; head_new.key = r_key;
               head_new.start = r_now; head_new.prio = r_prio;
               head_new.world = r_world;
            end
         endcase
      end
   end

   assign shift = (state_ff == FSM_SCAN);
   assign req_tready = (state_ff == FSM_IDLE) && !out_v_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE:   if (req_tvalid && req_tready) state_in = FSM_SCAN;
         FSM_SCAN:   if (cnt_ff == (VW+1)'(NUM_VOICES - 1))
                        state_in = (is_play && !pass_ff) ? FSM_DECIDE : FSM_DONE;
         FSM_DECIDE: state_in = dec_go ? FSM_SCAN : FSM_DONE;
         FSM_DONE:   state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FSM_IDLE;
      else state_ff <= state_in;
   end

   logic older_same, better_vic;
   assign older_same = !same_v_ff || (head.start < same_st_ff);
   assign better_vic = (head.prio < (vic_v_ff ? vic_prio_ff : PRIO_CEILING)) ||
                       ((head.prio == (vic_v_ff ? vic_prio_ff : PRIO_CEILING)) &&
                        (!vic_v_ff || head.start < vic_st_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd0; paused_ff <= 1'b0; out_v_ff <= 1'b0; started_ff <= '0;
      end else begin
         if (csr_we) count_ff <= csr_wdata;
         if (rsp_tvalid && rsp_tready) out_v_ff <= 1'b0;
         if (state_ff == FSM_IDLE && req_tvalid && req_tready) begin
            req_ff <= req_tdata;
            cnt_ff <= '0; pass_ff <= 1'b0; pos_ff <= VW'(NUM_VOICES - 1);
            vac_v_ff <= 1'b0; ex_v_ff <= 1'b0; same_v_ff <= 1'b0; vic_v_ff <= 1'b0;
            inst_ff <= '0; tgt_v_ff <= 1'b0;
            st_ff <= ST_OK; slot_ff <= 4'd0; evk_ff <= 64'd0; rs_ff <= RS_NONE;
         end
         if (state_ff == FSM_SCAN) begin
            cnt_ff <= cnt_ff + 1'b1;
            pos_ff <= pos_ff - 1'b1;
            if (!pass_ff) begin
               if (hit && !ex_v_ff) begin
                  ex_v_ff <= 1'b1; ex_ff <= pos_ff; ex_snd_ff <= head.sound;
                  if (r_op == OP_STOP_LOOP) slot_ff <= 4'(pos_ff);
               end
               if (!head.active) begin
                  // ring runs from high index to low: last seen free is lowest
                  vac_v_ff <= 1'b1; vac_ff <= pos_ff;
               end else begin
                  if (head.sound == r_handle) begin
                     inst_ff <= inst_ff + 1'b1;
                     if (older_same || head.start == same_st_ff) begin
                        same_v_ff <= 1'b1; same_ff <= pos_ff; same_st_ff <= head.start;
                     end
                  end
                  if (better_vic || (vic_v_ff && head.prio == vic_prio_ff &&
                                     head.start == vic_st_ff)) begin
                     vic_v_ff <= 1'b1; vic_ff <= pos_ff;
                     vic_prio_ff <= head.prio; vic_st_ff <= head.start;
                  end
               end
            end else if (tgt_v_ff && pos_ff == tgt_ff && head.active) begin
               evk_ff <= head.key;
            end
         end
         if (state_ff == FSM_DECIDE) begin
            st_ff <= dec_st; rs_ff <= dec_rs;
            slot_ff <= (dec_st == ST_OK) ? 4'(dec_tgt) : 4'd0;
            if (dec_go) begin
               tgt_v_ff <= 1'b1; tgt_ff <= dec_tgt; pass_ff <= 1'b1; cnt_ff <= '0;
               pos_ff <= VW'(NUM_VOICES - 1);
               started_ff[sidx] <= 1'b1;
            end
         end
         if (state_ff == FSM_DONE) begin
            out_v_ff <= 1'b1;
            case (r_op)
               OP_STOP_LOOP: if (!ex_v_ff) st_ff <= ST_MISSING;
               OP_RETIRE: slot_ff <= r_vidx;
               OP_PAUSE: paused_ff <= 1'b1;
               OP_RESUME: paused_ff <= 1'b0;
               OP_RESET: begin
                  paused_ff <= 1'b0;
                  for (int i = 0; i < NUM_SOUNDS; i++)
                     if (i < int'(count_ff)) started_ff[i] <= 1'b0;
               end
               default: ;
            endcase
         end
      end
   end

   // last start per sound; read is registered, stable well before decide
   always_ff @(posedge clock) begin
      if (state_ff == FSM_DECIDE && dec_go) last_ff[sidx] <= r_now;
      last_rd_ff <= last_ff[sidx];
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {7'd0, rs_ff, evk_ff, slot_ff, st_ff};
endmodule

### tb/sv/tb_top.sv
// Testbench for the voice allocator: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
   import ava_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [6:0]   csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // op[3] sound_id[7] loop_id[64] now_frame[32] priority_req[7] instance_cap[8]
   // drop_new[1] cooldown_frames[24] is_loop_sound[1] freezes[1] world_bus[1] voice_index[4]
   logic [159:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // status[3] slot[4] evicted_id[64] steal_cause[2]
   logic [79:0]  rsp_tdata;

   typedef struct packed {
      logic [3:0]  vidx;
      logic        world;
      logic        freeze;
      logic        loop_ok;
      logic [23:0] cool;
      logic        drop;
      logic [7:0]  maxi;
      logic [6:0]  prio;
      logic [31:0] now;
      logic [63:0] key;
      logic [6:0]  handle;
      op_type      op;
   } cmd_type;

   typedef struct packed {
      reason_type  reason;
      logic [63:0] evicted;
      logic [3:0]  slot;
      status_type  status;
   } verdict_type;

   audio_voice_allocator i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the voice table
   logic [6:0]  m_count;
   logic        m_active [NUM_VOICES];
   logic        m_stop   [NUM_VOICES];
   logic [6:0]  m_sound  [NUM_VOICES];
   logic [63:0] m_key    [NUM_VOICES];
   logic [31:0] m_start  [NUM_VOICES];
   logic [6:0]  m_prio   [NUM_VOICES];
   logic        m_world  [NUM_VOICES];
   logic        m_started[NUM_SOUNDS];
   logic [31:0] m_last   [NUM_SOUNDS];
   logic        m_paused;

   verdict_type expected_q[$];
   int       errors = 0;
   logic [31:0] frame_clock = '0;

   function automatic int loop_owner(logic [63:0] key);
      if (key == 0) return -1;
      for (int i = 0; i < NUM_VOICES; i++)
         if (m_active[i] && m_key[i] == key) return i;
      return -1;
   endfunction

   function automatic verdict_type allocate(cmd_type c);
      verdict_type v;
      int vacant, same, victim, target, ex, inst, s;
      logic [6:0] lowest;
      v = '{RS_NONE, 64'd0, 4'd0, ST_OK};
      vacant = -1; same = -1; victim = -1; inst = 0;
      if (c.handle == 0 || c.handle > m_count || c.handle > NUM_SOUNDS) begin
         v.status = ST_MISSING; return v;
      end
      s = c.handle - 1;
      if (c.op == OP_START_LOOP) begin
         if (c.key == 0 || !c.loop_ok) begin v.status = ST_INVALID; return v; end
         ex = loop_owner(c.key);
         if (ex >= 0) begin
            if (m_sound[ex] != c.handle) v.status = ST_CONFLICT;
            else v.slot = 4'(ex);
            return v;
         end
      end else if (c.key != 0) begin
         v.status = ST_INVALID; return v;
      end
      if (m_paused && c.freeze) begin v.status = ST_PAUSED; return v; end
      if (m_started[s] && (c.now - m_last[s]) < {8'd0, c.cool}) begin
         v.status = ST_COOLDOWN; return v;
      end
      for (int i = 0; i < NUM_VOICES; i++) begin
         if (!m_active[i]) begin
            if (vacant < 0) vacant = i;
            continue;
         end
         if (m_sound[i] == c.handle) begin
            inst++;
            if (same < 0 || m_start[i] < m_start[same]) same = i;
         end
         lowest = victim >= 0 ? m_prio[victim] : PRIO_CEILING;
         if (m_prio[i] < lowest ||
             (m_prio[i] == lowest && (victim < 0 || m_start[i] < m_start[victim])))
            victim = i;
      end
      if (inst >= c.maxi) begin
         if (c.drop || same < 0) begin v.status = ST_CAPACITY; return v; end
         target = same; v.reason = RS_INSTANCE;
      end else if (vacant < 0) begin
         if (victim < 0 || c.prio < m_prio[victim]) begin v.status = ST_PRIORITY; return v; end
         target = victim; v.reason = RS_GLOBAL;
      end else begin
         target = vacant;
      end
      if (m_active[target]) v.evicted = m_key[target];
      m_active[target] = 1'b1; m_stop[target] = 1'b0; m_sound[target] = c.handle;
      m_key[target] = c.key; m_start[target] = c.now; m_prio[target] = c.prio;
      m_world[target] = c.world;
      m_started[s] = 1'b1; m_last[s] = c.now;
      v.slot = 4'(target);
      return v;
   endfunction

   function automatic verdict_type apply_command(cmd_type c);
      verdict_type v;
      int i;
      v = '{RS_NONE, 64'd0, 4'd0, ST_OK};
      case (c.op)
         OP_PLAY, OP_START_LOOP: v = allocate(c);
         OP_STOP_LOOP: begin
            i = loop_owner(c.key);
            if (i < 0) v.status = ST_MISSING;
            else begin m_key[i] = '0; m_stop[i] = 1'b1; v.slot = 4'(i); end
         end
         OP_RETIRE: begin
            v.slot = c.vidx;
            m_active[c.vidx] = 1'b0; m_stop[c.vidx] = 1'b0;
         end
         OP_PAUSE:  m_paused = 1'b1;
         OP_RESUME: m_paused = 1'b0;
         OP_RESET: begin
            for (int k = 0; k < NUM_VOICES; k++) begin m_active[k] = 1'b0; m_stop[k] = 1'b0; end
            for (int k = 0; k < NUM_SOUNDS && k < m_count; k++) m_started[k] = 1'b0;
            m_paused = 1'b0;
         end
         default:
            for (int k = 0; k < NUM_VOICES; k++)
               if (m_active[k] && m_world[k]) begin m_active[k] = 1'b0; m_stop[k] = 1'b0; end
      endcase
      if (v.status != ST_OK) v = '{RS_NONE, 64'd0, 4'd0, v.status};
      return v;
   endfunction

   // send one command beat after a random gap; valid stays up until the next
   // gap or a drain lowers it (the block is busy by then)
   task automatic send_command(cmd_type c);
      int gap;
      gap = $urandom_range(0, 11) * ($urandom_range(0, 3) != 0);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {7'd0, c};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(apply_command(c));
      @(negedge clock);
   endtask

   // response side: random stall per beat, then compare with oldest expectation
   initial begin
      verdict_type got, want;
      int stall;
      forever begin
         @(negedge clock);
         stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = rsp_tdata[72:0];
         if (expected_q.size() == 0) begin
            $display("%t unexpected beat: actual %h", $time, got);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (got.status !== want.status)
               $display("%t status expected %0d actual %0d", $time, want.status, got.status);
            if (got.slot !== want.slot)
               $display("%t slot expected %0d actual %0d", $time, want.slot, got.slot);
            if (got.evicted !== want.evicted)
               $display("%t evicted key expected %h actual %h", $time, want.evicted, got.evicted);
            if (got.reason !== want.reason)
               $display("%t steal reason expected %0d actual %0d", $time, want.reason, got.reason);
            if (got !== want) errors++;
         end
      end
   end

   function automatic cmd_type blank_cmd(op_type op);
      cmd_type c;
      c = '0;
      c.op = op;
      c.maxi = 8'd255;
      c.now = frame_clock;
      return c;
   endfunction

   function automatic cmd_type play_cmd(logic [6:0] h, logic [6:0] p);
      cmd_type c;
      c = blank_cmd(OP_PLAY);
      c.handle = h; c.prio = p;
      return c;
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (2 * NUM_VOICES + 8) @(negedge clock);
   endtask

   task automatic write_count(logic [6:0] n);
      drain();
      csr_wdata <= n;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      m_count    = n;
   endtask

   // handle checks, loop key misuse, conflicts, stop loop, retire
   task automatic test_directed_checks();
      cmd_type c;
      write_count(7'd64);
      send_command(play_cmd(7'd0, 7'd5));           // handle zero
      send_command(play_cmd(7'd127, 7'd5));         // handle beyond catalog
      c = play_cmd(7'd1, 7'd5); c.key = 64'hFFFF_FFFF_FFFF_FFFF;
      send_command(c);                              // play with a key
      c.op = OP_START_LOOP; c.loop_ok = 1'b0;
      send_command(c);                              // not a loop sound
      c.loop_ok = 1'b1; c.world = 1'b1;
      send_command(c);                              // loop started
      send_command(c);                              // same key, same sound
      c.handle = 7'd2;
      send_command(c);                              // same key, other sound
      c = blank_cmd(OP_STOP_LOOP); c.key = 64'hFFFF_FFFF_FFFF_FFFF;
      send_command(c);
      send_command(c);                              // no longer matches
      c.key = '0;
      send_command(c);
      c = blank_cmd(OP_RETIRE); c.vidx = 4'd15;
      send_command(c);                              // inactive voice
      c.vidx = 4'd0;
      send_command(c);
   endtask

   // pause freeze, cooldown with wrap, instance limit and table full
   task automatic test_directed_limits();
      cmd_type c;
      send_command(blank_cmd(OP_PAUSE));
      c = play_cmd(7'd3, 7'd100); c.freeze = 1'b1;
      send_command(c);
      send_command(blank_cmd(OP_RESUME));
      c = play_cmd(7'd3, 7'd100); c.now = 32'hFFFF_FFF0; c.cool = 24'hFF_FFFF;
      send_command(c);
      c.now = 32'h0000_0010;                        // wrapped, still cooling
      send_command(c);
      c = play_cmd(7'd4, 7'd0); c.maxi = 8'd0;
      send_command(c);                              // no instance to steal
      c.drop = 1'b1;
      send_command(c);
      for (int i = 0; i < NUM_VOICES + 1; i++) send_command(play_cmd(7'd5, 7'd50));
      send_command(play_cmd(7'd6, 7'd10));          // priority too low
      c = play_cmd(7'd5, 7'd50); c.maxi = 8'd2;
      send_command(c);                              // instance steal
      send_command(blank_cmd(OP_CLEAR_WORLD));
      send_command(blank_cmd(OP_RESET));
   endtask

   // random commands over a small pool of handles and keys
   task automatic test_random(int n, logic [6:0] top_handle);
      cmd_type c;
      logic [63:0] keys[4];
      logic [159:0] noise;
      keys = '{64'd1, 64'h8000_0000_0000_0000, 64'hDEAD_BEEF_0123_4567, 64'd0};
      for (int i = 0; i < n; i++) begin
         noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
         c = noise[152:0];
         frame_clock += $urandom_range(0, 40);
         case ($urandom_range(0, 19))
            0,1,2,3,4,5,6,7: c.op = OP_PLAY;
            8,9,10,11:       c.op = OP_START_LOOP;
            12,13:           c.op = OP_STOP_LOOP;
            14,15:           c.op = OP_RETIRE;
            16:              c.op = OP_PAUSE;
            17:              c.op = OP_RESUME;
            18:              c.op = $urandom_range(0, 9) == 0 ? OP_RESET : OP_CLEAR_WORLD;
            default:         c.op = op_type'($urandom_range(0, 7));
         endcase
         if ($urandom_range(0, 7) != 0) begin
            c.handle = 7'($urandom_range(1, top_handle));
            c.now    = frame_clock;
            c.prio   = 7'($urandom_range(0, 100));
            c.maxi   = 8'($urandom_range(0, 5));
            c.cool   = $urandom_range(0, 3) == 0 ? 24'($urandom_range(0, 60)) : 24'd0;
            c.key    = c.op == OP_PLAY ? 64'd0 : keys[$urandom_range(0, 3)];
            if (c.op == OP_START_LOOP) c.loop_ok = $urandom_range(0, 5) != 0;
         end
         send_command(c);
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_VOICES; i++) begin
         m_active[i] = 1'b0; m_stop[i] = 1'b0; m_sound[i] = '0; m_key[i] = '0;
         m_start[i] = '0; m_prio[i] = '0; m_world[i] = 1'b0;
      end
      for (int i = 0; i < NUM_SOUNDS; i++) begin m_started[i] = 1'b0; m_last[i] = '0; end
      m_paused = 1'b0; m_count = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_command(play_cmd(7'd1, 7'd5));           // empty catalog
      test_directed_checks();
      test_directed_limits();
      test_random(300, 7'd6);
      drain();                                      // sender holds off until all answered
      write_count(7'd3);
      test_random(150, 7'd5);
      write_count(7'd127);
      test_random(200, 7'd70);
      write_count(7'd0);
      test_random(30, 7'd3);
      drain();
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

### sim.f
rtl/ava_pkg.sv
rtl/ava_cell.sv
rtl/audio_voice_allocator.sv
tb/sv/tb_top.sv
